>>> rtl/banked_memory_with_destructive_read_defines.svh
// ----------------------------------------------------------------------------
// Banked memory assertion macros
// Clocked implication checks used by the banked memory top-level module.
// ----------------------------------------------------------------------------
`ifndef BANKED_MEMORY_WITH_DESTRUCTIVE_READ_DEFINES_SVH
`define BANKED_MEMORY_WITH_DESTRUCTIVE_READ_DEFINES_SVH

// same-cycle implication
`define BMDR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bmdr: same-cycle check failed");

// next-cycle implication
`define BMDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bmdr: next-cycle check failed");

`endif

>>> rtl/bmdr_pkg.sv
// ----------------------------------------------------------------------------
// Banked memory package
// Opcodes, status codes, region kinds, decode result and a word helper.
// ----------------------------------------------------------------------------
package bmdr_pkg;

	localparam int unsigned DATA_W     = 16;
	localparam int unsigned ADDR_W     = 16;
	localparam int unsigned BANK_W     = 5;
	localparam int unsigned LIDX_W     = 15;
	localparam int unsigned ERAS_DEPTH = 1024;
	localparam int unsigned ERAS_AW    = 10;
	localparam int unsigned REG_END    = 'o20;
	localparam int unsigned FIDX_W     = 18;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_LOAD  = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_REGISTER  = 2'd1,
		ST_BANK_ZERO = 2'd2,
		ST_UNMAPPED  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_ERAS  = 2'd1,
		KIND_FIXED = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		status_t             status;
		logic [ERAS_AW-1:0]  eidx;
		logic [FIDX_W-1:0]   fidx;
	} dec_t;

	// bit 15 (mask 0x4000) takes a copy of bit 16 (mask 0x8000)
	function automatic logic [DATA_W-1:0] copy_sign(logic [DATA_W-1:0] w);
		return {w[DATA_W-1], w[DATA_W-1], w[DATA_W-3:0]};
	endfunction

endpackage

>>> rtl/bmdr_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one memory operation per transfer.
// ----------------------------------------------------------------------------
interface bmdr_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [15:0] address;
	logic [4:0]  bank;
	logic [15:0] write_data;
	logic [14:0] load_index;

	modport source (
		output valid, opcode, address, bank, write_data, load_index,
		input  ready
	);

	modport sink (
		input  valid, opcode, address, bank, write_data, load_index,
		output ready
	);
endinterface

>>> rtl/bmdr_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one read result per transfer.
// ----------------------------------------------------------------------------
interface bmdr_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_data;
	logic [1:0]  status;

	modport source (
		output valid, read_data, status,
		input  ready
	);

	modport sink (
		input  valid, read_data, status,
		output ready
	);
endinterface

>>> rtl/banked_memory_with_destructive_read.sv
// ----------------------------------------------------------------------------
// Banked memory with destructive read
// Latency: a read result is valid the cycle after its request transfer.
// Throughput: one operation per cycle while responses are taken; a pending
// result blocks new requests until it transfers (single-port RAM reads).
// Reset: arst_n clears the result valid flag only; store contents are
// undefined until written or loaded.
// ----------------------------------------------------------------------------
`include "banked_memory_with_destructive_read_defines.svh"

module banked_memory_with_destructive_read
	import bmdr_pkg::*;
#(
	parameter int unsigned ERASABLE_END      = 1023,
	parameter int unsigned FIXED_FIXED_START = 1024,
	parameter int unsigned FIXED_FIXED_END   = 3071,
	parameter int unsigned BANKED_START      = 3072,
	parameter int unsigned BANK_WORDS        = 1024,
	parameter int unsigned FIXED_WORDS       = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	bmdr_req_if.sink    req,
	bmdr_rsp_if.source  rsp
);

	localparam int unsigned FA_W = $clog2(FIXED_WORDS);

	dec_t              dec;
	logic              xfer;
	logic              is_read;
	logic              eras_rd;
	logic              eras_wr;
	logic              fix_rd;
	logic              fix_wr;
	logic [FIDX_W-1:0] lidx;
	logic [FA_W-1:0]   fix_idx;
	logic [DATA_W-1:0] eras_rdata;
	logic [DATA_W-1:0] fix_rdata;
	logic              valid_q;
	status_t           status_q;
	kind_t             kind_q;

	bmdr_decode #(
		.ERASABLE_END      (ERASABLE_END),
		.FIXED_FIXED_START (FIXED_FIXED_START),
		.FIXED_FIXED_END   (FIXED_FIXED_END),
		.BANKED_START      (BANKED_START),
		.BANK_WORDS        (BANK_WORDS),
		.FIXED_WORDS       (FIXED_WORDS)
	) u_decode (
		.address (req.address),
		.bank    (req.bank),
		.dec     (dec)
	);

	assign req.ready = !valid_q || rsp.ready;
	assign xfer      = req.valid && req.ready;
	assign is_read   = req.opcode == OP_READ;

	assign lidx    = FIDX_W'(req.load_index);
	assign eras_rd = xfer && is_read && dec.kind == KIND_ERAS;
	assign eras_wr = xfer && req.opcode == OP_WRITE && dec.kind == KIND_ERAS;
	assign fix_rd  = xfer && is_read && dec.kind == KIND_FIXED;
	assign fix_wr  = xfer && req.opcode == OP_LOAD && 32'(lidx) < FIXED_WORDS;
	assign fix_idx = fix_wr ? lidx[FA_W-1:0] : dec.fidx[FA_W-1:0];

	bmdr_erasable u_erasable (
		.clk   (clk),
		.rd    (eras_rd),
		.wr    (eras_wr),
		.idx   (dec.eidx),
		.wdata (copy_sign(req.write_data)),
		.rdata (eras_rdata)
	);

	bmdr_fixed #(
		.FIXED_WORDS (FIXED_WORDS),
		.FA_W        (FA_W)
	) u_fixed (
		.clk   (clk),
		.rd    (fix_rd),
		.wr    (fix_wr),
		.idx   (fix_idx),
		.wdata (req.write_data),
		.rdata (fix_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (xfer && is_read) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer && is_read) begin
			status_q <= dec.status;
			kind_q   <= dec.kind;
		end
	end

	assign rsp.valid  = valid_q;
	assign rsp.status = status_q;

	always_comb begin
		case (kind_q)
			KIND_ERAS:  rsp.read_data = copy_sign(eras_rdata);
			KIND_FIXED: rsp.read_data = copy_sign(fix_rdata);
			default:    rsp.read_data = '0;
		endcase
	end

	`BMDR_ASSERT_NEXT(a_read_gives_result, clk, arst_n,
		req.valid && req.ready && req.opcode == OP_READ, rsp.valid)
	`BMDR_ASSERT_NOW(a_error_reads_zero, clk, arst_n,
		rsp.valid && rsp.status != ST_OK, rsp.read_data == '0)
	`BMDR_ASSERT_NOW(a_stall_blocks_request, clk, arst_n,
		rsp.valid && !rsp.ready, !req.ready)
	`BMDR_ASSERT_NEXT(a_write_no_result, clk, arst_n,
		req.valid && req.ready && req.opcode != OP_READ && !(rsp.valid && !rsp.ready),
		!rsp.valid)

endmodule

>>> rtl/bmdr_decode.sv
// ----------------------------------------------------------------------------
// Address decode
// Splits a machine address into register area, erasable, fixed-fixed and
// banked regions and forms the store index.
// ----------------------------------------------------------------------------
module bmdr_decode
	import bmdr_pkg::*;
#(
	parameter int unsigned ERASABLE_END      = 1023,
	parameter int unsigned FIXED_FIXED_START = 1024,
	parameter int unsigned FIXED_FIXED_END   = 3071,
	parameter int unsigned BANKED_START      = 3072,
	parameter int unsigned BANK_WORDS        = 1024,
	parameter int unsigned FIXED_WORDS       = 32768
) (
	input  logic [ADDR_W-1:0] address,
	input  logic [BANK_W-1:0] bank,
	output dec_t              dec
);

	logic [31:0]       a32;
	logic [BANK_W-1:0] bank_m1;
	logic [FIDX_W-1:0] fidx;
	logic              hit;

	assign a32     = 32'(address);
	assign bank_m1 = bank - BANK_W'(1);

	always_comb begin
		dec        = '0;
		dec.kind   = KIND_NONE;
		dec.status = ST_UNMAPPED;
		dec.eidx   = address[ERAS_AW-1:0];
		fidx       = '0;
		hit        = 1'b0;
		if (a32 < REG_END) begin
			dec.status = ST_REGISTER;
		end else if (a32 <= ERASABLE_END) begin
			if (a32 < ERAS_DEPTH) begin
				dec.kind   = KIND_ERAS;
				dec.status = ST_OK;
			end
		end else begin
			if (a32 >= FIXED_FIXED_START && a32 <= FIXED_FIXED_END) begin
				fidx = FIDX_W'(a32 - FIXED_FIXED_START);
				hit  = 1'b1;
			end else if (a32 >= BANKED_START && (a32 - BANKED_START) < BANK_WORDS) begin
				if (bank == '0) begin
					dec.status = ST_BANK_ZERO;
				end else begin
					fidx = FIDX_W'(a32 - BANKED_START)
						+ FIDX_W'(bank_m1) * FIDX_W'(BANK_WORDS);
					hit  = 1'b1;
				end
			end
			if (hit && 32'(fidx) < FIXED_WORDS) begin
				dec.kind   = KIND_FIXED;
				dec.status = ST_OK;
			end
		end
		dec.fidx = fidx;
	end

endmodule

>>> rtl/bmdr_erasable.sv
// ----------------------------------------------------------------------------
// Erasable store
// Single-port synchronous RAM; a read returns the old word and clears the
// entry in the same access.
// ----------------------------------------------------------------------------
module bmdr_erasable
	import bmdr_pkg::*;
(
	input  logic               clk,
	input  logic               rd,
	input  logic               wr,
	input  logic [ERAS_AW-1:0] idx,
	input  logic [DATA_W-1:0]  wdata,
	output logic [DATA_W-1:0]  rdata
);

	logic [DATA_W-1:0] mem [ERAS_DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (rd) begin
			rdata_q  <= mem[idx];
			mem[idx] <= '0;
		end else if (wr) begin
			mem[idx] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/bmdr_fixed.sv
// ----------------------------------------------------------------------------
// Fixed store
// Single-port synchronous RAM, loaded word by word, registered read.
// ----------------------------------------------------------------------------
module bmdr_fixed
	import bmdr_pkg::*;
#(
	parameter int unsigned FIXED_WORDS = 32768,
	parameter int unsigned FA_W        = $clog2(FIXED_WORDS)
) (
	input  logic              clk,
	input  logic              rd,
	input  logic              wr,
	input  logic [FA_W-1:0]   idx,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [FIXED_WORDS];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[idx] <= wdata;
		end else if (rd) begin
			rdata_q <= mem[idx];
		end
	end

	assign rdata = rdata_q;

endmodule
